@@ sv/pfm_pkg.sv @@
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared types and constants of the position feedback monitor.
// ----------------------------------------------------------------------------
package pfm_pkg;

    // number of monitored bus nodes (1..8)
    localparam int NODES = 6;
    localparam int IDXW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [7:0] ALL_MASK = 8'((1 << NODES) - 1);

    // event kinds
    localparam logic [1:0] OP_REQ  = 2'd0;
    localparam logic [1:0] OP_RESP = 2'd1;
    localparam logic [1:0] OP_TMO  = 2'd2;

    // reset value of the skew limit
    localparam logic [31:0] SKEW_RESET = 32'd2000;

    // floor(x / 1000) = (x * RECIP) >> 41 for x < 2^31
    localparam logic [31:0] RECIP = 32'd2199023256;

    // event queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // classified event word
    typedef struct packed {
        logic [1:0]      op;
        logic            node_ok;   // node number is 1..NODES
        logic            bcast;     // node number is 0
        logic [IDXW-1:0] idx;       // node number - 1
        logic [31:0]     time_us;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_MULT,
        ST_EMIT
    } t_state;

endpackage

@@ sv/pfm_queue.sv @@
// ----------------------------------------------------------------------------
// pfm_queue
// Short first-in first-out queue of classified event words.
// ----------------------------------------------------------------------------
module pfm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pfm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pfm_pkg::t_item o_item
);
    pfm_pkg::t_item r_mem [pfm_pkg::QDEPTH];
    logic [pfm_pkg::QAW-1:0] r_wp, r_rp;
    logic [pfm_pkg::QAW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (pfm_pkg::QAW+1)'(pfm_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == pfm_pkg::QAW'(pfm_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == pfm_pkg::QAW'(pfm_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (pfm_pkg::QAW+1)'(do_push) - (pfm_pkg::QAW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

@@ sv/pfm_front.sv @@
// ----------------------------------------------------------------------------
// pfm_front
// Accepts event words and classifies the node number for the back end.
// ----------------------------------------------------------------------------
module pfm_front (
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_opcode,
    input  logic [7:0]     i_node_number,
    input  logic [31:0]    i_time_us,
    input  logic           i_q_full,
    output logic           o_push,
    output pfm_pkg::t_item o_item
);
    logic [7:0] node_m1;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign node_m1 = i_node_number - 8'd1;

    // classify
    always_comb begin
        o_item.op      = i_opcode;
        o_item.node_ok = (i_node_number >= 8'd1) && (i_node_number <= 8'(pfm_pkg::NODES));
        o_item.bcast   = (i_node_number == 8'd0);
        o_item.idx     = node_m1[pfm_pkg::IDXW-1:0];
        o_item.time_us = i_time_us;
    end
endmodule

@@ sv/pfm_back.sv @@
// ----------------------------------------------------------------------------
// pfm_back
// Per-node state, sweep tracking, coherence check and result register.
// ----------------------------------------------------------------------------
module pfm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    input  logic           i_q_valid,
    input  pfm_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [175:0]   o_data,
    output logic           o_user
);
    localparam logic [pfm_pkg::IDXW-1:0] LAST = pfm_pkg::IDXW'(pfm_pkg::NODES - 1);

    // per-node state
    logic        r_pend  [pfm_pkg::NODES];
    logic        r_seen  [pfm_pkg::NODES];
    logic [31:0] r_last  [pfm_pkg::NODES];
    logic [31:0] r_ans   [pfm_pkg::NODES];
    logic [31:0] r_asked [pfm_pkg::NODES];
    logic [31:0] r_total [pfm_pkg::NODES];
    logic [15:0] r_run   [pfm_pkg::NODES];

    // global state
    logic [31:0] r_max_skew, r_cur_sweep, r_coh_sweep, r_coh_skew;
    logic [7:0]  r_mask;
    logic        r_coh_ok;

    // sequencer
    pfm_pkg::t_state r_state, n_state;
    pfm_pkg::t_item  r_item;
    logic [pfm_pkg::IDXW-1:0] r_idx;

    // captured node result
    logic        r_o_pend, r_o_seen;
    logic [15:0] r_o_run;
    logic [31:0] r_o_total, r_o_sweep, r_el;
    logic [31:0] r_lo, r_hi;
    logic        r_fail;
    logic [62:0] r_prod;

    // output register
    logic         r_ov, r_ouser;
    logic [175:0] r_odata;

    // control
    logic take, scan_en, check_en, mult_en, emit_en, out_free, is_last;
    always_comb begin
        out_free = !r_ov || i_ready;
        is_last  = (r_idx == LAST);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfm_pkg::ST_IDLE:  if (i_q_valid) n_state = pfm_pkg::ST_SCAN;
            pfm_pkg::ST_SCAN:  if (is_last) n_state = pfm_pkg::ST_CHECK;
            pfm_pkg::ST_CHECK: if (is_last) n_state = pfm_pkg::ST_MULT;
            pfm_pkg::ST_MULT:  n_state = pfm_pkg::ST_EMIT;
            pfm_pkg::ST_EMIT:  if (out_free) n_state = pfm_pkg::ST_IDLE;
            default:           n_state = pfm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        take = 1'b0; scan_en = 1'b0; check_en = 1'b0; mult_en = 1'b0; emit_en = 1'b0;
        case (r_state)
            pfm_pkg::ST_IDLE:  take     = i_q_valid;
            pfm_pkg::ST_SCAN:  scan_en  = 1'b1;
            pfm_pkg::ST_CHECK: check_en = 1'b1;
            pfm_pkg::ST_MULT:  mult_en  = 1'b1;
            pfm_pkg::ST_EMIT:  emit_en  = out_free;
            default:           take     = 1'b0;
        endcase
    end
    assign o_q_pop = take;

    // sweep advance on a request
    logic [7:0]  bit_sel, n_mask;
    logic [31:0] sweep_inc, n_cur_sweep;
    logic        adv;
    always_comb begin
        bit_sel   = 8'd1 << i_q_item.idx;
        sweep_inc = (r_cur_sweep == 32'hFFFF_FFFF) ? 32'd1 : r_cur_sweep + 32'd1;
        adv       = 1'b0;
        n_mask    = r_mask;
        if (i_q_item.op == pfm_pkg::OP_REQ) begin
            if (i_q_item.bcast) begin
                adv    = (r_mask != 8'd0);
                n_mask = pfm_pkg::ALL_MASK;
            end else if (i_q_item.node_ok) begin
                adv    = (r_mask == pfm_pkg::ALL_MASK) || ((r_mask & bit_sel) != 8'd0);
                n_mask = (adv ? 8'd0 : r_mask) | bit_sel;
            end
        end
        n_cur_sweep = adv ? sweep_inc : r_cur_sweep;
    end

    // update of the node under the scan index
    logic        hit, ask, resp, tmo, loss;
    logic        nx_pend, nx_seen;
    logic [15:0] nx_run;
    logic [31:0] nx_total, nx_asked, nx_ans, nx_last;
    always_comb begin
        hit  = r_item.node_ok && (r_item.idx == r_idx);
        ask  = (r_item.op == pfm_pkg::OP_REQ) && (r_item.bcast || hit);
        resp = (r_item.op == pfm_pkg::OP_RESP) && hit;
        tmo  = (r_item.op == pfm_pkg::OP_TMO) && hit;
        loss = (ask || tmo) && r_pend[r_idx];
        nx_total = (loss && r_total[r_idx] != 32'hFFFF_FFFF) ? r_total[r_idx] + 32'd1
                                                             : r_total[r_idx];
        nx_run   = resp ? 16'd0 :
                   (loss && r_run[r_idx] != 16'hFFFF) ? r_run[r_idx] + 16'd1 : r_run[r_idx];
        nx_pend  = ask ? 1'b1 : (resp || tmo) ? 1'b0 : r_pend[r_idx];
        nx_asked = ask ? r_cur_sweep : r_asked[r_idx];
        nx_ans   = resp ? r_asked[r_idx] : r_ans[r_idx];
        nx_seen  = resp || r_seen[r_idx];
        nx_last  = resp ? r_item.time_us : r_last[r_idx];
    end

    // coherence step over the check index
    logic [31:0] age_i;
    logic        mismatch, chk_en;
    always_comb begin
        age_i    = r_item.time_us - r_last[r_idx];
        mismatch = !r_seen[r_idx] || (r_ans[r_idx] != r_o_sweep);
        chk_en   = (r_item.op == pfm_pkg::OP_RESP) && r_item.node_ok && (r_o_sweep != 32'd0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfm_pkg::ST_IDLE;
            r_idx       <= '0;
            r_max_skew  <= pfm_pkg::SKEW_RESET;
            r_cur_sweep <= 32'd1;
            r_mask      <= 8'd0;
            r_coh_sweep <= 32'd0;
            r_coh_skew  <= 32'd0;
            r_coh_ok    <= 1'b0;
            r_ov        <= 1'b0;
            for (int i = 0; i < pfm_pkg::NODES; i++) begin
                r_pend[i]  <= 1'b0;
                r_seen[i]  <= 1'b0;
                r_last[i]  <= 32'd0;
                r_ans[i]   <= 32'd0;
                r_asked[i] <= 32'd0;
                r_total[i] <= 32'd0;
                r_run[i]   <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_skew <= i_cfg_wdata;
            end
            if (take) begin
                r_cur_sweep <= n_cur_sweep;
                r_mask      <= n_mask;
            end
            if (take || ((scan_en || check_en) && is_last)) begin
                r_idx <= '0;
            end else if (scan_en || check_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (scan_en) begin
                for (int i = 0; i < pfm_pkg::NODES; i++) begin
                    if (r_idx == pfm_pkg::IDXW'(i)) begin
                        r_pend[i]  <= nx_pend;
                        r_seen[i]  <= nx_seen;
                        r_last[i]  <= nx_last;
                        r_ans[i]   <= nx_ans;
                        r_asked[i] <= nx_asked;
                        r_total[i] <= nx_total;
                        r_run[i]   <= nx_run;
                    end
                end
            end
            if (mult_en && chk_en && !r_fail) begin
                r_coh_sweep <= r_o_sweep;
                r_coh_skew  <= r_hi - r_lo;
                r_coh_ok    <= (r_hi - r_lo) <= r_max_skew;
            end
            if (emit_en) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    logic [21:0] age_ms;
    always_comb begin
        age_ms = (r_o_seen && !r_el[31]) ? r_prod[62:41] : 22'd0;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item    <= i_q_item;
            r_o_pend  <= 1'b0;
            r_o_seen  <= 1'b0;
            r_o_run   <= 16'd0;
            r_o_total <= 32'd0;
            r_o_sweep <= 32'd0;
            r_el      <= 32'd0;
        end
        if (scan_en && hit) begin
            r_o_pend  <= nx_pend;
            r_o_seen  <= nx_seen;
            r_o_run   <= nx_run;
            r_o_total <= nx_total;
            r_o_sweep <= nx_ans;
            r_el      <= r_item.time_us - nx_last;
        end
        if (check_en) begin
            if (r_idx == '0) begin
                r_fail <= mismatch;
                r_lo   <= age_i;
                r_hi   <= age_i;
            end else begin
                r_fail <= r_fail || mismatch;
                if (age_i < r_lo) r_lo <= age_i;
                if (age_i > r_hi) r_hi <= age_i;
            end
        end
        if (mult_en) begin
            r_prod <= r_el[30:0] * pfm_pkg::RECIP;
        end
        if (emit_en) begin
            r_ouser <= r_item.node_ok;
            r_odata <= {7'd0, r_coh_skew, r_coh_sweep, r_coh_ok, r_o_sweep, age_ms,
                        r_o_total, r_o_run, r_o_seen, r_o_pend};
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;

    // the sweep number never reads zero
    a_sweep_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_sweep != 32'd0) else $error("sweep number is zero");

    // asked mask holds only existing nodes
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask & ~pfm_pkg::ALL_MASK) == 8'd0) else $error("mask names missing node");

    // a finished event shows up as a valid result word
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_en |=> r_ov) else $error("result not presented");

    // queue is only popped from idle
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == pfm_pkg::ST_IDLE) && i_q_valid) else $error("bad pop");
endmodule

@@ sv/position_feedback_monitor.sv @@
// ----------------------------------------------------------------------------
// position_feedback_monitor
// Request/response tracker for a fixed set of bus nodes.
// ----------------------------------------------------------------------------
// Usage: event words enter on the s_axis channel (tuser = opcode, tdata =
// node number and microsecond time); each event yields one status word on
// the m_axis channel (tuser = node_valid). The skew limit is written through
// i_cfg_we/i_cfg_wdata while the block is idle.
// Each event passes through the back end in order: one pass over the node
// registers applies the update, a second pass checks sweep coherence, then a
// multiply step turns elapsed time into ms and the result register is loaded.
// The back end takes the next event only once the last one is done; a
// two-word queue lets the input run ahead.
// Reset clears all per-node state, sets the sweep number to one and the skew
// limit to 2000 us. When the receiver stalls, the result word holds, the back
// end waits, and input is accepted until the queue fills.
// ----------------------------------------------------------------------------
module position_feedback_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // node_number[7:0], time_us[39:8]
    input  logic [1:0]   s_axis_tuser,   // opcode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // node_pending[0], node_seen[1], run_losses[17:2], all_losses[49:18],
    // age_ms[71:50], node_sweep[103:72], sweep_coherent[104],
    // coherent_sweep[136:105], sweep_skew_us[168:137], zero fill
    output logic [175:0] m_axis_tdata,
    output logic         m_axis_tuser    // node_valid[0]
);
    logic           q_full, push, q_valid, q_pop;
    pfm_pkg::t_item f_item, q_item;

    pfm_front u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .i_node_number (s_axis_tdata[7:0]),
        .i_time_us     (s_axis_tdata[39:8]),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (f_item)
    );

    pfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pfm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_user      (m_axis_tuser)
    );
endmodule
